[rtl/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
// Used by mcr_ctrl, mcr_datapath and midpoint_circle_rasterizer; no dependencies.
`default_nettype none

package mcr_pkg;

  // Field widths
  localparam int unsigned COORD_BITS  = 8;
  localparam int unsigned RADIUS_BITS = 7;
  localparam int unsigned OUT_BITS    = 10;
  localparam int unsigned DEC_BITS    = 10;

  // Radius clamp and run length limit
  localparam logic [RADIUS_BITS-1:0] MAX_RADIUS = RADIUS_BITS'(88);
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_BITS    = $clog2(MAX_RESULTS);
  localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(MAX_RESULTS - 1);

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_RAW_BITS  = 2 * COORD_BITS + RADIUS_BITS;
  localparam int unsigned IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = ((8 * OUT_BITS + 7) / 8) * 8;

  typedef logic signed [OUT_BITS-1:0] coord_t;

  // One result: the eight symmetric coordinates, x_plus_dx in the lowest bits
  typedef struct packed {
    coord_t y_minus_dx;
    coord_t y_plus_dx;
    coord_t y_minus_dy;
    coord_t y_plus_dy;
    coord_t x_minus_dy;
    coord_t x_plus_dy;
    coord_t x_minus_dx;
    coord_t x_plus_dx;
  } points_t;

  // Controller state, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic end_run;
  } status_t;

endpackage

`default_nettype wire

[rtl/mcr_ctrl.sv]
// Sequencer for the midpoint circle rasterizer: request handshakes and step issue.
// Depends on mcr_pkg.
`default_nettype none

module mcr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output mcr_pkg::cmd_t         cmd_o,
  input  wire mcr_pkg::status_t status_i
);

  mcr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // Take a request only between circles
  assign s_axis_tready = (state_q == mcr_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

  // Issue a step when the output register is free or being drained
  always_comb begin
    cmd_o.load = s_axis_tvalid && s_axis_tready;
    cmd_o.step = (state_q == mcr_pkg::ST_RUN) && (!out_valid_q || m_axis_tready);
  end

  // Next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      mcr_pkg::ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = mcr_pkg::ST_RUN;
        end
      end
      mcr_pkg::ST_RUN: begin
        if (cmd_o.step && status_i.end_run) begin
          state_d = mcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mcr_datapath.sv]
// Datapath for the midpoint circle rasterizer: offsets, decision value,
// step count and the result register. Depends on mcr_pkg.
`default_nettype none

module mcr_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mcr_pkg::cmd_t                       cmd_i,
  input  wire logic [mcr_pkg::COORD_BITS-1:0]      centre_x_i,
  input  wire logic [mcr_pkg::COORD_BITS-1:0]      centre_y_i,
  input  wire logic [mcr_pkg::RADIUS_BITS-1:0]     radius_i,
  output mcr_pkg::status_t                         status_o,
  output mcr_pkg::points_t                         points_o,
  output logic                                     last_step_o
);

  localparam int unsigned RB = mcr_pkg::RADIUS_BITS;
  localparam int unsigned CB = mcr_pkg::COORD_BITS;
  localparam int unsigned OB = mcr_pkg::OUT_BITS;
  localparam int unsigned DB = mcr_pkg::DEC_BITS;

  logic [RB-1:0]                 offset_x_q, offset_x_d;
  logic [RB-1:0]                 offset_y_q, offset_y_d;
  logic signed [DB-1:0]          decision_q, decision_d;
  logic [CB-1:0]                 centre_x_q, centre_y_q;
  logic [mcr_pkg::CNT_BITS-1:0]  cnt_q;
  mcr_pkg::points_t              points_q, points_d;
  logic                          last_q;

  logic [RB-1:0]                 radius_sat;
  logic signed [RB+1:0]          dx_new, dy_new;
  logic signed [DB:0]            dec_sum;
  logic                          done;
  mcr_pkg::coord_t               cx, cy, dx, dy;

  // Clamp the radius
  assign radius_sat = (radius_i > mcr_pkg::MAX_RADIUS) ? mcr_pkg::MAX_RADIUS : radius_i;

  // Plot the current offsets around the held centre
  always_comb begin
    cx = OB'(centre_x_q);
    cy = OB'(centre_y_q);
    dx = OB'(offset_x_q);
    dy = OB'(offset_y_q);
    points_d.x_plus_dx  = cx + dx;
    points_d.x_minus_dx = cx - dx;
    points_d.x_plus_dy  = cx + dy;
    points_d.x_minus_dy = cx - dy;
    points_d.y_plus_dy  = cy + dy;
    points_d.y_minus_dy = cy - dy;
    points_d.y_plus_dx  = cy + dx;
    points_d.y_minus_dx = cy - dx;
  end

  // Advance the offsets and the decision value
  always_comb begin
    dx_new = $signed({2'b00, offset_x_q}) + (RB+2)'(1);
    if (decision_q < 0) begin
      dy_new  = $signed({2'b00, offset_y_q});
      dec_sum = (DB+1)'(decision_q) + (DB+1)'(dx_new <<< 1) + (DB+1)'(1);
    end else begin
      dy_new  = $signed({2'b00, offset_y_q}) - (RB+2)'(1);
      dec_sum = (DB+1)'(decision_q) + (DB+1)'(dx_new <<< 1) + (DB+1)'(1)
              - (DB+1)'(dy_new <<< 1);
    end
    decision_d = dec_sum[DB-1:0];
    offset_x_d = dx_new[RB-1:0];
    offset_y_d = dy_new[RB+1] ? '0 : dy_new[RB-1:0];
    done       = dx_new > dy_new;
  end

  assign status_o.end_run = done || (cnt_q == mcr_pkg::LAST_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + mcr_pkg::CNT_BITS'(1);
    end
  end

  // Load a new circle or take one octant step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= '0;
      centre_y_q <= '0;
      offset_x_q <= '0;
      offset_y_q <= '0;
      decision_q <= '0;
      points_q   <= '0;
      last_q     <= 1'b0;
    end else if (cmd_i.load) begin
      centre_x_q <= centre_x_i;
      centre_y_q <= centre_y_i;
      offset_x_q <= '0;
      offset_y_q <= radius_sat;
      decision_q <= DB'(1) - DB'(radius_sat);
    end else if (cmd_i.step) begin
      offset_x_q <= offset_x_d;
      offset_y_q <= offset_y_d;
      decision_q <= decision_d;
      points_q   <= points_d;
      last_q     <= done;
    end
  end

  assign points_o    = points_q;
  assign last_step_o = last_q;

endmodule

`default_nettype wire

[rtl/midpoint_circle_rasterizer.sv]
// Top level of the midpoint circle rasterizer: stream ports, controller and datapath.
// Depends on mcr_pkg, mcr_ctrl and mcr_datapath.
`default_nettype none

// One request carries a circle centre and a radius (above 88 it is clamped
// to 88). The block answers with one result per step of the first octant,
// starting at offset (0, r), each holding the four x and four y coordinates
// of the eight symmetric points as 10-bit two's complement values; tlast
// marks the final step. A circle of radius r gives about r/sqrt(2)+1
// results, at most 63. The octant walk produces one result per cycle while
// the output is taken, one step of the decision update loop each cycle; a
// new request is taken in the cycle after the last step of a circle.
// While a request is taken, the last result of the previous circle may
// still wait in the output register.
module midpoint_circle_rasterizer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // centre_x [7:0], centre_y [15:8], radius [22:16], zero [23]
  input  wire logic [mcr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // x_plus_dx [9:0], x_minus_dx [19:10], x_plus_dy [29:20], x_minus_dy [39:30],
  // y_plus_dy [49:40], y_minus_dy [59:50], y_plus_dx [69:60], y_minus_dx [79:70]
  output logic [mcr_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,
  // last_step
  output logic                                    m_axis_tlast
);

  localparam int unsigned CB = mcr_pkg::COORD_BITS;
  localparam int unsigned RB = mcr_pkg::RADIUS_BITS;

  mcr_pkg::cmd_t    cmd;
  mcr_pkg::status_t status;
  mcr_pkg::points_t points;

  mcr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  mcr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .centre_x_i  (s_axis_tdata[CB-1:0]),
    .centre_y_i  (s_axis_tdata[2*CB-1:CB]),
    .radius_i    (s_axis_tdata[2*CB+RB-1:2*CB]),
    .status_o    (status),
    .points_o    (points),
    .last_step_o (m_axis_tlast)
  );

  assign m_axis_tdata = mcr_pkg::OUT_DATA_BITS'(points);

endmodule

`default_nettype wire
